### rtl/rgb_to_hsv_8bit_core_macros.svh
// Assertion macros used by the RGB to HSV converter core.
`ifndef RGB_TO_HSV_8BIT_CORE_MACROS_SVH
`define RGB_TO_HSV_8BIT_CORE_MACROS_SVH
`ifndef SYNTH
// Same-cycle implication, disabled while reset is high.
`define RTHSV_ASSERT_IMPLIES(label, clk, rst, ante, cons) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
      else $error("rthsv implication check failed");
// Next-cycle implication, disabled while reset is high.
`define RTHSV_ASSERT_NEXT(label, clk, rst, ante, cons) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
      else $error("rthsv next-cycle check failed");
`else
`define RTHSV_ASSERT_IMPLIES(label, clk, rst, ante, cons)
`define RTHSV_ASSERT_NEXT(label, clk, rst, ante, cons)
`endif
`endif

### rtl/rthsv_pkg.sv
// Types, constants and helper functions of the RGB to HSV converter.
package rthsv_pkg;

   typedef struct packed {
      logic [7:0] red;
      logic [7:0] green;
      logic [7:0] blue;
   } rgb_pixel_type;

   typedef struct packed {
      logic [7:0] hue;
      logic [7:0] saturation;
      logic [7:0] brightness;
   } hsv_pixel_type;

   typedef enum logic [1:0] {
      SECTOR_RED,
      SECTOR_GREEN,
      SECTOR_BLUE
   } sector_type;

   // Per-pixel information that bypasses the dividers.
   typedef struct packed {
      logic       zero_range;
      logic       negative;
      sector_type sector;
      logic [7:0] brightness;
   } side_type;

   localparam logic [7:0] SAT_SCALE      = 8'd255;
   localparam logic [7:0] HUE_SCALE      = 8'd43;
   localparam logic [7:0] HUE_BASE_RED   = 8'd0;
   localparam logic [7:0] HUE_BASE_GREEN = 8'd85;
   localparam logic [7:0] HUE_BASE_BLUE  = 8'd171;

   localparam int DIV_STAGES         = 4;
   localparam int DIV_BITS_PER_STAGE = 2;
   localparam int PREP_STAGES        = 2;
   localparam int PIPE_LATENCY       = PREP_STAGES + DIV_STAGES + 1;

   // One divider stage: partial remainder, unconsumed numerator bits,
   // quotient so far and divisor.
   typedef struct packed {
      logic [7:0] rem;
      logic [7:0] low;
      logic [7:0] quo;
      logic [7:0] den;
   } div_stage_type;

   // Retire quotient bits of one stage by restoring division.
   function automatic div_stage_type div_advance(input div_stage_type cur);
      div_stage_type nxt;
      logic [8:0]    trial;
      nxt = cur;
      for (int i = 0; i < DIV_BITS_PER_STAGE; i++) begin
         trial   = {nxt.rem, nxt.low[7]};
         nxt.low = {nxt.low[6:0], 1'b0};
         if (trial >= {1'b0, nxt.den}) begin
            trial   = trial - {1'b0, nxt.den};
            nxt.quo = {nxt.quo[6:0], 1'b1};
         end else begin
            nxt.quo = {nxt.quo[6:0], 1'b0};
         end
         nxt.rem = trial[7:0];
      end
      return nxt;
   endfunction

   function automatic logic [7:0] hue_base(input sector_type sector);
      logic [7:0] base;
      unique case (sector)
         SECTOR_RED:   base = HUE_BASE_RED;
         SECTOR_GREEN: base = HUE_BASE_GREEN;
         SECTOR_BLUE:  base = HUE_BASE_BLUE;
         default:      base = HUE_BASE_RED;
      endcase
      return base;
   endfunction

endpackage

### rtl/rgb_to_hsv_8bit_core.sv
// Converts a stream of 8-bit RGB pixels to 8-bit HSV, one pixel per clock, through
// seven register stages, with rsp_valid carried alongside the data through every one.
// Two front stages find max, min, sector and the divider operands, two four-stage
// restoring dividers (two quotient bits per stage) form saturation and the hue
// offset side by side, and one stage adds the sector base and registers the result.
// busy is always low, so a transaction can be started on every clock. Each result
// is shown for exactly one cycle with rsp_valid high; the receiver must take it then.
`include "rgb_to_hsv_8bit_core_macros.svh"
module rgb_to_hsv_8bit_core (
   input  logic                     clock,
   input  logic                     reset,
   input  logic                     start,
   output logic                     busy,
   input  rthsv_pkg::rgb_pixel_type req_pixel,
   output logic                     rsp_valid,
   output rthsv_pkg::hsv_pixel_type rsp_pixel
);

   logic                accept;
   logic                prep_valid;
   logic [15:0]         sat_num;
   logic [7:0]          sat_den;
   logic [15:0]         hue_num;
   logic [7:0]          hue_den;
   rthsv_pkg::side_type prep_side;
   logic [7:0]          sat_quo;
   logic [7:0]          hue_quo;

   logic                side_valid_ff [rthsv_pkg::DIV_STAGES];
   rthsv_pkg::side_type side_ff       [rthsv_pkg::DIV_STAGES];

   assign busy   = 1'b0;
   assign accept = start && !busy;

   rthsv_prep u_prep (
      .clock     (clock),
      .reset     (reset),
      .in_valid  (accept),
      .in_pixel  (req_pixel),
      .out_valid (prep_valid),
      .sat_num   (sat_num),
      .sat_den   (sat_den),
      .hue_num   (hue_num),
      .hue_den   (hue_den),
      .out_side  (prep_side)
   );

   rthsv_div u_sat_div (
      .clock (clock),
      .num   (sat_num),
      .den   (sat_den),
      .quo   (sat_quo)
   );

   rthsv_div u_hue_div (
      .clock (clock),
      .num   (hue_num),
      .den   (hue_den),
      .quo   (hue_quo)
   );

   // Carry valid and sideband alongside the divider stages.
   always_ff @(posedge clock) begin
      if (reset) begin
         for (int s = 0; s < rthsv_pkg::DIV_STAGES; s++) begin
            side_valid_ff[s] <= 1'b0;
         end
      end else begin
         side_valid_ff[0] <= prep_valid;
         for (int s = 1; s < rthsv_pkg::DIV_STAGES; s++) begin
            side_valid_ff[s] <= side_valid_ff[s-1];
         end
      end
      side_ff[0] <= prep_side;
      for (int s = 1; s < rthsv_pkg::DIV_STAGES; s++) begin
         side_ff[s] <= side_ff[s-1];
      end
   end

   rthsv_post u_post (
      .clock     (clock),
      .reset     (reset),
      .in_valid  (side_valid_ff[rthsv_pkg::DIV_STAGES-1]),
      .in_side   (side_ff[rthsv_pkg::DIV_STAGES-1]),
      .sat_quo   (sat_quo),
      .hue_quo   (hue_quo),
      .out_valid (rsp_valid),
      .out_pixel (rsp_pixel)
   );

   `RTHSV_ASSERT_IMPLIES(a_rsp_from_accept, clock, reset, rsp_valid,
      $past(accept, rthsv_pkg::PIPE_LATENCY))
   `RTHSV_ASSERT_IMPLIES(a_gray_hue_zero, clock, reset,
      rsp_valid && (rsp_pixel.saturation == 8'h00), rsp_pixel.hue == 8'h00)
   `RTHSV_ASSERT_IMPLIES(a_black_sat_zero, clock, reset,
      rsp_valid && (rsp_pixel.brightness == 8'h00), rsp_pixel.saturation == 8'h00)
   `RTHSV_ASSERT_NEXT(a_side_valid_track, clock, reset, prep_valid, side_valid_ff[0])

endmodule

### rtl/rthsv_prep.sv
// Front stages: channel max/min, sector choice and divider operands.
module rthsv_prep (
   input  logic                     clock,
   input  logic                     reset,
   input  logic                     in_valid,
   input  rthsv_pkg::rgb_pixel_type in_pixel,
   output logic                     out_valid,
   output logic [15:0]              sat_num,
   output logic [7:0]               sat_den,
   output logic [15:0]              hue_num,
   output logic [7:0]               hue_den,
   output rthsv_pkg::side_type      out_side
);

   logic                  max_valid_ff;
   logic [7:0]            max_value_ff, max_value_in;
   logic [7:0]            range_ff, range_in;
   logic [7:0]            abs_diff_ff, abs_diff_in;
   logic                  negative_ff, negative_in;
   rthsv_pkg::sector_type sector_ff, sector_in;

   logic                  num_valid_ff;
   logic [15:0]           sat_num_ff, sat_num_in;
   logic [15:0]           hue_num_ff, hue_num_in;
   logic [7:0]            range_b_ff;
   rthsv_pkg::side_type   side_ff, side_in;

   logic [7:0]            min_value;
   logic [7:0]            diff_a;
   logic [7:0]            diff_b;

   always_comb begin
      // Ties: red first, then green.
      if (in_pixel.red >= in_pixel.green && in_pixel.red >= in_pixel.blue) begin
         sector_in    = rthsv_pkg::SECTOR_RED;
         max_value_in = in_pixel.red;
         diff_a       = in_pixel.green;
         diff_b       = in_pixel.blue;
      end else if (in_pixel.green >= in_pixel.blue) begin
         sector_in    = rthsv_pkg::SECTOR_GREEN;
         max_value_in = in_pixel.green;
         diff_a       = in_pixel.blue;
         diff_b       = in_pixel.red;
      end else begin
         sector_in    = rthsv_pkg::SECTOR_BLUE;
         max_value_in = in_pixel.blue;
         diff_a       = in_pixel.red;
         diff_b       = in_pixel.green;
      end
      min_value = (in_pixel.red < in_pixel.green) ? in_pixel.red : in_pixel.green;
      if (in_pixel.blue < min_value) begin
         min_value = in_pixel.blue;
      end
      range_in    = max_value_in - min_value;
      negative_in = (diff_a < diff_b);
      abs_diff_in = negative_in ? (diff_b - diff_a) : (diff_a - diff_b);
   end

   always_comb begin
      sat_num_in         = {8'h00, range_ff} * {8'h00, rthsv_pkg::SAT_SCALE};
      hue_num_in         = {8'h00, abs_diff_ff} * {8'h00, rthsv_pkg::HUE_SCALE};
      side_in.zero_range = (range_ff == 8'h00);
      side_in.negative   = negative_ff;
      side_in.sector     = sector_ff;
      side_in.brightness = max_value_ff;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         max_valid_ff <= 1'b0;
         num_valid_ff <= 1'b0;
      end else begin
         max_valid_ff <= in_valid;
         num_valid_ff <= max_valid_ff;
      end
      max_value_ff <= max_value_in;
      range_ff     <= range_in;
      abs_diff_ff  <= abs_diff_in;
      negative_ff  <= negative_in;
      sector_ff    <= sector_in;
      sat_num_ff   <= sat_num_in;
      hue_num_ff   <= hue_num_in;
      range_b_ff   <= range_ff;
      side_ff      <= side_in;
   end

   assign out_valid = num_valid_ff;
   assign sat_num   = sat_num_ff;
   assign sat_den   = side_ff.brightness;
   assign hue_num   = hue_num_ff;
   assign hue_den   = range_b_ff;
   assign out_side  = side_ff;

endmodule

### rtl/rthsv_div.sv
// Pipelined restoring divider for quotients known to fit in eight bits.
module rthsv_div (
   input  logic        clock,
   input  logic [15:0] num,
   input  logic [7:0]  den,
   output logic [7:0]  quo
);

   rthsv_pkg::div_stage_type stage_src [rthsv_pkg::DIV_STAGES];
   rthsv_pkg::div_stage_type stage_in  [rthsv_pkg::DIV_STAGES];
   rthsv_pkg::div_stage_type stage_ff  [rthsv_pkg::DIV_STAGES];

   always_comb begin
      // Upper numerator byte is below the divisor, so it seeds the remainder.
      stage_src[0].rem = num[15:8];
      stage_src[0].low = num[7:0];
      stage_src[0].quo = 8'h00;
      stage_src[0].den = den;
      for (int s = 1; s < rthsv_pkg::DIV_STAGES; s++) begin
         stage_src[s] = stage_ff[s-1];
      end
      for (int s = 0; s < rthsv_pkg::DIV_STAGES; s++) begin
         stage_in[s] = rthsv_pkg::div_advance(stage_src[s]);
      end
   end

   always_ff @(posedge clock) begin
      for (int s = 0; s < rthsv_pkg::DIV_STAGES; s++) begin
         stage_ff[s] <= stage_in[s];
      end
   end

   assign quo = stage_ff[rthsv_pkg::DIV_STAGES-1].quo;

endmodule

### rtl/rthsv_post.sv
// Output stage: sector base plus signed hue offset, special cases, result register.
module rthsv_post (
   input  logic                     clock,
   input  logic                     reset,
   input  logic                     in_valid,
   input  rthsv_pkg::side_type      in_side,
   input  logic [7:0]               sat_quo,
   input  logic [7:0]               hue_quo,
   output logic                     out_valid,
   output rthsv_pkg::hsv_pixel_type out_pixel
);

   logic                     valid_ff;
   rthsv_pkg::hsv_pixel_type pixel_ff, pixel_in;
   logic [7:0]               hue_offset;

   always_comb begin
      hue_offset = in_side.negative ? (8'h00 - hue_quo) : hue_quo;
      pixel_in.brightness = in_side.brightness;
      // Gray and black pixels: drop both divider results.
      if (in_side.zero_range) begin
         pixel_in.hue        = 8'h00;
         pixel_in.saturation = 8'h00;
      end else begin
         pixel_in.hue        = rthsv_pkg::hue_base(in_side.sector) + hue_offset;
         pixel_in.saturation = sat_quo;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff <= 1'b0;
      end else begin
         valid_ff <= in_valid;
      end
      pixel_ff <= pixel_in;
   end

   assign out_valid = valid_ff;
   assign out_pixel = pixel_ff;

endmodule
